@@ rtl/alse_pkg.sv @@
// Shared types and constants for the addressable LED slot encoder.
// Depends on nothing; every RTL file refers to it by scoped names.
`default_nettype none
package alse_pkg;

  localparam int PIXEL_COUNT       = 64;
  localparam int RESET_LEAD_SLOTS  = 50;
  localparam int RESET_TRAIL_SLOTS = 50;
  localparam int BITS_PER_PIXEL    = 24;

  localparam int PIX_W   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int BIT_W   = $clog2(BITS_PER_PIXEL);
  localparam int RST_MAX = (RESET_LEAD_SLOTS > RESET_TRAIL_SLOTS) ?
                           RESET_LEAD_SLOTS : RESET_TRAIL_SLOTS;
  localparam int CNT_W   = $clog2(RST_MAX + 2);

  localparam logic [PIX_W-1:0] PIX_LAST   = PIX_W'(PIXEL_COUNT - 1);
  localparam logic [BIT_W-1:0] BIT_LAST   = BIT_W'(BITS_PER_PIXEL - 1);
  localparam logic [CNT_W-1:0] LEAD_LAST  =
    CNT_W'((RESET_LEAD_SLOTS > 0) ? RESET_LEAD_SLOTS - 1 : 0);
  localparam logic [CNT_W-1:0] TRAIL_LAST =
    CNT_W'((RESET_TRAIL_SLOTS > 0) ? RESET_TRAIL_SLOTS - 1 : 0);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_CODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  pixel_index;
    logic [23:0] color;
  } item_t;

  typedef struct packed {
    logic [7:0] slot_value;
    logic       frame_last;
  } result_t;

  typedef struct packed {
    logic             active;
    logic             in_data;
    logic [PIX_W-1:0] pix;
    logic [BIT_W-1:0] bitn;
    logic             last;
  } slot_pos_t;

endpackage
`default_nettype wire

@@ rtl/addressable_led_slot_encoder.sv @@
// Top level of the addressable LED slot encoder: control FSM, codes, output register.
// Depends on alse_pkg, alse_pixel_store and alse_slot_ctr.
//
// Usage:
//   item channel   : opcode write stores a colour at pixel_index (ignored when
//                    not below the pixel count), start begins a frame at slot
//                    zero, tick asks for the next slot of an active frame.
//   result channel : one transaction per tick inside a frame: the slot duty
//                    value and a flag on the final slot of the frame.
//   cfg channel    : index 0 one_code, index 1 zero_code; always ready.
// Result path: a reset-slot tick's zero-valued result goes straight to the output
//   register; a data-slot tick reads the colour memory, then S_READ forms the result.
// Acceptance: write and start never drop item_ready, nor does a reset-slot tick
//   while the output register is free; a data-slot tick drops it until S_READ ends.
// Reset clears the codes, the frame state and every written flag, so pixels
//   never written send zero-valued slots; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register and a
//   following result waits in a holding register; item_ready drops until the
//   output register frees.
`default_nettype none
module addressable_led_slot_encoder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire alse_pkg::item_t                item,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output alse_pkg::result_t                   result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [alse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_HOLD
  } state_t;

  state_t                      state;
  logic [7:0]                  one_code;
  logic [7:0]                  zero_code;
  alse_pkg::result_t           pend;
  logic [alse_pkg::BIT_W-1:0]  bitq;
  logic                        lastq;

  alse_pkg::slot_pos_t         pos;
  logic                        accept;
  logic                        is_write;
  logic                        is_start;
  logic                        is_tick;
  logic                        in_range;
  logic                        out_free;
  logic                        out_load;
  alse_pkg::result_t           out_data;
  logic [23:0]                 rd_color;
  logic                        rd_written;
  logic [23:0]                 grb;
  logic [alse_pkg::BIT_W-1:0]  grb_idx;
  alse_pkg::result_t           data_res;
  alse_pkg::result_t           reset_res;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && item_ready;
  assign in_range   = ({1'b0, item.pixel_index} < 11'(alse_pkg::PIXEL_COUNT));
  assign is_write   = accept && (item.opcode == alse_pkg::OP_WRITE) && in_range;
  assign is_start   = accept && (item.opcode == alse_pkg::OP_START);
  assign is_tick    = accept && (item.opcode == alse_pkg::OP_TICK) && pos.active;
  assign out_free   = !result_valid || result_ready;

  assign grb     = {rd_color[15:8], rd_color[23:16], rd_color[7:0]};
  assign grb_idx = alse_pkg::BIT_LAST - bitq;

  always_comb begin
    data_res.frame_last = lastq;
    data_res.slot_value = !rd_written ? 8'd0 : (grb[grb_idx] ? one_code : zero_code);
    reset_res.frame_last = pos.last;
    reset_res.slot_value = 8'd0;
  end

  always_comb begin
    out_load = 1'b0;
    out_data = pend;
    case (state)
      S_IDLE: begin
        if (is_tick && !pos.in_data && out_free) begin
          out_load = 1'b1;
          out_data = reset_res;
        end
      end
      S_READ: begin
        out_load = out_free;
        out_data = data_res;
      end
      S_HOLD: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  alse_pixel_store u_store (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (is_write),
    .wr_addr    (item.pixel_index[alse_pkg::PIX_W-1:0]),
    .wr_color   (item.color),
    .rd_en      (is_tick && pos.in_data),
    .rd_addr    (pos.pix),
    .rd_color   (rd_color),
    .rd_written (rd_written)
  );

  alse_slot_ctr u_ctr (
    .clk     (clk),
    .rst     (rst),
    .start   (is_start),
    .advance (is_tick),
    .pos     (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      one_code  <= 8'd0;
      zero_code <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        alse_pkg::CFG_ONE_CODE:  one_code  <= cfg_data;
        alse_pkg::CFG_ZERO_CODE: zero_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= out_load || (result_valid && !result_ready);
      if (out_load) begin
        result <= out_data;
      end
      case (state)
        S_IDLE: begin
          if (is_tick) begin
            if (pos.in_data) begin
              bitq  <= pos.bitn;
              lastq <= pos.last;
              state <= S_READ;
            end else if (!out_free) begin
              pend  <= reset_res;
              state <= S_HOLD;
            end
          end
        end
        S_READ: begin
          if (out_free) begin
            state <= S_IDLE;
          end else begin
            pend  <= data_res;
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/alse_pixel_store.sv @@
// Pixel colour memory with one write and one registered read port, plus
// per-pixel written flags cleared by reset. Depends on alse_pkg.
`default_nettype none
module alse_pixel_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr_en,
  input  wire logic [alse_pkg::PIX_W-1:0] wr_addr,
  input  wire logic [23:0]               wr_color,
  input  wire logic                      rd_en,
  input  wire logic [alse_pkg::PIX_W-1:0] rd_addr,
  output logic      [23:0]               rd_color,
  output logic                           rd_written
);

  logic [23:0] mem [alse_pkg::PIXEL_COUNT];
  logic [alse_pkg::PIXEL_COUNT-1:0] written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_color;
    end
    if (rd_en) begin
      rd_color <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/alse_slot_ctr.sv @@
// Frame position counters: lead reset slots, pixel and bit, trail reset slots.
// Depends on alse_pkg.
`default_nettype none
module alse_slot_ctr (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          advance,
  output alse_pkg::slot_pos_t pos
);

  typedef enum logic [1:0] {
    PH_OFF,
    PH_LEAD,
    PH_DATA,
    PH_TRAIL
  } phase_t;

  phase_t                       phase;
  logic [alse_pkg::CNT_W-1:0]   cnt;
  logic [alse_pkg::PIX_W-1:0]   pix;
  logic [alse_pkg::BIT_W-1:0]   bitn;
  logic                         last;

  always_comb begin
    last = ((phase == PH_DATA) && (bitn == alse_pkg::BIT_LAST) &&
            (pix == alse_pkg::PIX_LAST) && (alse_pkg::RESET_TRAIL_SLOTS == 0)) ||
           ((phase == PH_TRAIL) && (cnt == alse_pkg::TRAIL_LAST));
    pos.active  = (phase != PH_OFF);
    pos.in_data = (phase == PH_DATA);
    pos.pix     = pix;
    pos.bitn    = bitn;
    pos.last    = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OFF;
      cnt   <= '0;
      pix   <= '0;
      bitn  <= '0;
    end else if (start) begin
      phase <= (alse_pkg::RESET_LEAD_SLOTS > 0) ? PH_LEAD : PH_DATA;
      cnt   <= '0;
      pix   <= '0;
      bitn  <= '0;
    end else if (advance) begin
      case (phase)
        PH_LEAD: begin
          if (cnt == alse_pkg::LEAD_LAST) begin
            phase <= PH_DATA;
            pix   <= '0;
            bitn  <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        PH_DATA: begin
          if (bitn == alse_pkg::BIT_LAST) begin
            bitn <= '0;
            if (pix == alse_pkg::PIX_LAST) begin
              cnt   <= '0;
              phase <= (alse_pkg::RESET_TRAIL_SLOTS > 0) ? PH_TRAIL : PH_OFF;
            end else begin
              pix <= pix + 1'b1;
            end
          end else begin
            bitn <= bitn + 1'b1;
          end
        end
        PH_TRAIL: begin
          if (last) begin
            phase <= PH_OFF;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          phase <= PH_OFF;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/alse_checker.sv @@
// Port-level checks for the addressable LED slot encoder, bound to the top level.
// Depends on alse_pkg.
`default_nettype none
module alse_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire alse_pkg::item_t   item,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire alse_pkg::result_t result
);

  a_result_hold : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_reset_quiet : assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_no_result_from_non_tick : assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.opcode != alse_pkg::OP_TICK) |=>
      !result_valid || ($past(result_valid) && !$past(result_ready)))
    else $error("result produced by a non-tick transaction");

  a_read_completes : assert property (@(posedge clk) disable iff (rst)
    !item_ready && !result_valid |=> result_valid)
    else $error("data slot read did not complete");

endmodule

bind addressable_led_slot_encoder alse_checker u_alse_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
`default_nettype wire
